### design/cfms_pkg.sv
// ----------------------------------------------------------------------------
// cfms_pkg: shared types and constants for the CAN FD message segmenter
// Beat layout of the frame word stream, pad descriptor and helper functions.
// ----------------------------------------------------------------------------
package cfms_pkg;

    localparam int unsigned ID_W     = 29;
    localparam int unsigned LEN_W    = 14;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned SEQ_W    = 8;

    localparam logic [LEN_W-1:0] MAX_LENGTH  = 14'd15809;
    localparam logic [POS_W-1:0] HEADER_LEN  = 7'd2;
    localparam logic [POS_W-1:0] FRAME_BYTES = 7'd64;
    localparam logic [IDX_W-1:0] LAST_WORD   = 3'd7;

    // length / 62 is computed as (length / 2) / 31 through a reciprocal
    // multiply; 33826 / 2^20 is exact for every dividend up to 34880.
    localparam logic [15:0] RECIP_31    = 16'd33826;
    localparam int unsigned RECIP_SHIFT = 20;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic [WORD_W-1:0] frame_word;
        logic [IDX_W-1:0]  word_index;
        logic              frame_end;
        logic              message_end;
        logic              burst_end;
    } cfms_beat_t;

    // Describes the padding run that closes a message: words start_idx..7.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  start_idx;
        logic              last_frame;
    } cfms_pad_t;

    function automatic logic [SEQ_W-1:0] div62(input logic [LEN_W-1:0] len);
        logic [28:0] prod;
        prod = 29'(len[LEN_W-1:1]) * 29'(RECIP_31);
        return prod[RECIP_SHIFT+SEQ_W-1:RECIP_SHIFT];
    endfunction

    function automatic logic [WORD_W-1:0] frame_header(input logic [SEQ_W-1:0] seq,
                                                       input logic [SEQ_W-1:0] total);
        return {48'd0, total, seq};
    endfunction

endpackage

### design/cfms_in_if.sv
// ----------------------------------------------------------------------------
// cfms_in_if: input item channel of the segmenter
// Valid/ready channel carrying start items (id, length) and data bytes.
// ----------------------------------------------------------------------------
interface cfms_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [28:0] msg_id;
    logic [13:0] msg_length;
    logic [7:0]  data_byte;

    modport source (output valid, output op, output msg_id, output msg_length,
                    output data_byte, input ready);
    modport sink   (input valid, input op, input msg_id, input msg_length,
                    input data_byte, output ready);
endinterface

### design/cfms_out_if.sv
// ----------------------------------------------------------------------------
// cfms_out_if: frame word channel of the segmenter
// Valid/ready channel carrying one 64-bit frame word per beat with markers.
// ----------------------------------------------------------------------------
interface cfms_out_if;
    logic        valid;
    logic        ready;
    logic [28:0] frame_id;
    logic [63:0] frame_word;
    logic [2:0]  word_index;
    logic        frame_end;
    logic        message_end;
    logic        burst_end;

    modport source (output valid, output frame_id, output frame_word, output word_index,
                    output frame_end, output message_end, output burst_end, input ready);
    modport sink   (input valid, input frame_id, input frame_word, input word_index,
                    input frame_end, input message_end, input burst_end, output ready);
endinterface

### design/cfms_core.sv
// ----------------------------------------------------------------------------
// cfms_core: message state and frame assembly
// Keeps the message state, packs bytes into frame words and reports a
// completed word and the padding run that an accepted item causes.
// ----------------------------------------------------------------------------
module cfms_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          op,
    input  logic [cfms_pkg::ID_W-1:0]     msg_id,
    input  logic [cfms_pkg::LEN_W-1:0]    msg_length,
    input  logic [cfms_pkg::BYTE_W-1:0]   data_byte,
    output logic                          word_valid,
    output cfms_pkg::cfms_beat_t          word_beat,
    output cfms_pkg::cfms_pad_t           pad
);
    import cfms_pkg::*;

    logic               busy_reg, busy_next;
    logic [ID_W-1:0]    held_id_reg, held_id_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;
    logic [SEQ_W-1:0]   total_reg, total_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [WORD_W-1:0]  acc_reg, acc_next;

    logic [LEN_W-1:0]   len_sat;
    logic [WORD_W-1:0]  acc_or;
    logic [POS_W-1:0]   pos_inc;

    always_comb
    begin
        busy_next       = busy_reg;
        held_id_next    = held_id_reg;
        bytes_left_next = bytes_left_reg;
        seq_next        = seq_reg;
        total_next      = total_reg;
        pos_next        = pos_reg;
        acc_next        = acc_reg;
        word_valid      = 1'b0;
        word_beat       = '0;
        pad             = '0;
        len_sat         = (msg_length > MAX_LENGTH) ? MAX_LENGTH : msg_length;
        acc_or          = acc_reg | ({56'd0, data_byte} << {pos_reg[2:0], 3'b000});
        pos_inc         = pos_reg + 7'd1;

        if (accept)
        begin
            if (op == OP_START)
            begin
                held_id_next    = msg_id;
                bytes_left_next = len_sat;
                total_next      = div62(len_sat) + 8'd1;
                seq_next        = 8'd1;
                busy_next       = 1'b1;
                acc_next        = frame_header(8'd1, total_next);
                pos_next        = HEADER_LEN;
            end
            else if (busy_reg)
            begin
                if (bytes_left_reg != '0)
                begin
                    bytes_left_next = bytes_left_reg - 14'd1;
                end
                pos_next = pos_inc;
                if (pos_inc[2:0] == 3'd0)
                begin
                    word_valid             = 1'b1;
                    word_beat.frame_id     = held_id_reg;
                    word_beat.frame_word   = acc_or;
                    word_beat.word_index   = pos_reg[5:3];
                    word_beat.frame_end    = (pos_reg[5:3] == LAST_WORD);
                    word_beat.message_end  = (pos_reg[5:3] == LAST_WORD) &&
                                             (seq_reg == total_reg);
                    acc_next               = '0;
                end
                else
                begin
                    acc_next = acc_or;
                end
                if (pos_inc == FRAME_BYTES)
                begin
                    if (seq_reg < total_reg)
                    begin
                        seq_next = seq_reg + 8'd1;
                        acc_next = frame_header(seq_next, total_reg);
                        pos_next = HEADER_LEN;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
            end

            // Once the last payload byte is in, the rest of the frame is padding.
            if (busy_next && (bytes_left_next == '0))
            begin
                pad.valid      = 1'b1;
                pad.id         = held_id_next;
                pad.word       = acc_next;
                pad.start_idx  = pos_next[5:3];
                pad.last_frame = (seq_next == total_next);
                busy_next      = 1'b0;
                acc_next       = '0;
                pos_next       = FRAME_BYTES;
            end
        end
        word_beat.burst_end = !pad.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            held_id_reg    <= '0;
            bytes_left_reg <= '0;
            seq_reg        <= '0;
            total_reg      <= '0;
            pos_reg        <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            held_id_reg    <= held_id_next;
            bytes_left_reg <= bytes_left_next;
            seq_reg        <= seq_next;
            total_reg      <= total_next;
            pos_reg        <= pos_next;
            acc_reg        <= acc_next;
        end
    end

`ifndef SYNTHESIS
    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pos_reg >= HEADER_LEN) && (pos_reg < FRAME_BYTES))
        else $error("byte position outside the frame body while busy");

    a_seq_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (seq_reg != 8'd0) && (seq_reg <= total_reg))
        else $error("sequence number outside 1..total while busy");

    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> accept && (op == OP_DATA) && busy_reg)
        else $error("completed word without an accepted data beat");
`endif

endmodule

### design/cfms_emit.sv
// ----------------------------------------------------------------------------
// cfms_emit: output register and padding generator
// Holds the outgoing beat and plays out padding words one per cycle while the output slot is free.
// ----------------------------------------------------------------------------
module cfms_emit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic                  word_valid,
    input  cfms_pkg::cfms_beat_t  word_beat,
    input  cfms_pkg::cfms_pad_t   pad,
    output logic                  can_accept,
    cfms_out_if.source            out_ch
);
    import cfms_pkg::*;

    logic              out_valid_reg, out_valid_next;
    cfms_beat_t        out_reg, out_next;
    logic              pad_active_reg, pad_active_next;
    logic [ID_W-1:0]   pad_id_reg, pad_id_next;
    logic [WORD_W-1:0] pad_word_reg, pad_word_next;
    logic [IDX_W-1:0]  pad_idx_reg, pad_idx_next;
    logic              pad_last_reg, pad_last_next;
    logic              slot_free;

    assign slot_free  = !out_valid_reg || out_ch.ready;
    assign can_accept = !pad_active_reg && slot_free;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_next        = out_reg;
        pad_active_next = pad_active_reg;
        pad_id_next     = pad_id_reg;
        pad_word_next   = pad_word_reg;
        pad_idx_next    = pad_idx_reg;
        pad_last_next   = pad_last_reg;

        if (load && word_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = word_beat;
        end
        else if (pad_active_reg && slot_free)
        begin
            out_valid_next       = 1'b1;
            out_next.frame_id    = pad_id_reg;
            out_next.frame_word  = pad_word_reg;
            out_next.word_index  = pad_idx_reg;
            out_next.frame_end   = (pad_idx_reg == LAST_WORD);
            out_next.message_end = (pad_idx_reg == LAST_WORD) && pad_last_reg;
            out_next.burst_end   = (pad_idx_reg == LAST_WORD);
            pad_word_next        = '0;
            pad_idx_next         = pad_idx_reg + 3'd1;
            if (pad_idx_reg == LAST_WORD)
            begin
                pad_active_next = 1'b0;
            end
        end

        if (load && pad.valid)
        begin
            pad_active_next = 1'b1;
            pad_id_next     = pad.id;
            pad_word_next   = pad.word;
            pad_idx_next    = pad.start_idx;
            pad_last_next   = pad.last_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pad_active_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pad_active_reg <= pad_active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        pad_id_reg   <= pad_id_next;
        pad_word_reg <= pad_word_next;
        pad_idx_reg  <= pad_idx_next;
        pad_last_reg <= pad_last_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.frame_id    = out_reg.frame_id;
    assign out_ch.frame_word  = out_reg.frame_word;
    assign out_ch.word_index  = out_reg.word_index;
    assign out_ch.frame_end   = out_reg.frame_end;
    assign out_ch.message_end = out_reg.message_end;
    assign out_ch.burst_end   = out_reg.burst_end;

`ifndef SYNTHESIS
    a_no_pad_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        load && pad.valid |-> !pad_active_reg)
        else $error("new padding run started while one is still playing out");

    a_pad_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(pad_active_reg) |-> out_valid_reg && out_reg.burst_end &&
                                  (out_reg.word_index == LAST_WORD))
        else $error("padding run ended without a closing beat");

    a_pad_continues: assert property (@(posedge clk) disable iff (!rst_n)
        pad_active_reg && slot_free && (pad_idx_reg != LAST_WORD) |=> pad_active_reg)
        else $error("padding run stopped before the last word");
`endif

endmodule

### design/can_fd_message_segmenter_top.sv
// ----------------------------------------------------------------------------
// can_fd_message_segmenter_top: CAN FD message segmenter
// Cuts a message into 64-byte frames (sequence, count, 62 payload bytes)
// and sends each frame as eight 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes a start beat (op = 0) with the 29-bit id and the payload
//   length, then one data beat (op = 1) per payload byte. A start beat while
//   a message is open drops that message; data beats with no open message
//   are discarded. Lengths above 15809 are clipped to 15809.
//   out_ch gives frame words with word_index, frame_end, message_end and
//   burst_end (last word caused by one input beat).
//   A word appears on out_ch in the cycle after the beat that completes it.
//   in_ch takes one beat per cycle while out_ch keeps up and no padding is pending.
//   When the final payload byte (or the start of an empty message) arrives,
//   the padding words of the last frame follow one per cycle while out_ch
//   keeps up, and in_ch is held off until they have all entered the output
//   register.
//   A stall on out_ch holds the output register and, through ready, in_ch.
//   Reset clears the message state and drops any word not yet delivered;
//   the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module can_fd_message_segmenter_top
(
    input  logic       clk,
    input  logic       rst_n,
    cfms_in_if.sink    in_ch,
    cfms_out_if.source out_ch
);
    import cfms_pkg::*;

    logic       accept;
    logic       can_accept;
    logic       word_valid;
    cfms_beat_t word_beat;
    cfms_pad_t  pad;

    assign in_ch.ready = can_accept;
    assign accept      = in_ch.valid && can_accept;

    cfms_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (in_ch.op),
        .msg_id     (in_ch.msg_id),
        .msg_length (in_ch.msg_length),
        .data_byte  (in_ch.data_byte),
        .word_valid (word_valid),
        .word_beat  (word_beat),
        .pad        (pad)
    );

    cfms_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .word_valid (word_valid),
        .word_beat  (word_beat),
        .pad        (pad),
        .can_accept (can_accept),
        .out_ch     (out_ch)
    );

endmodule
